// ----- src/ffcra_pkg.sv -----
// ----------------------------------------------------------------------------
// ffcra_pkg: shared types and constants for the first-fit cell region allocator
// Commands, status codes, sequencer states and the in/out beat structs.
// ----------------------------------------------------------------------------
package ffcra_pkg;

  localparam int unsigned TapeCellsDef  = 256;
  localparam int unsigned MaxRegionsDef = 16;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned SizeW  = 9;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned AddrW  = 8;
  localparam int unsigned StatW  = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_ALLOC     = 2'd0,
    CMD_FREE_SLOT = 2'd1,
    CMD_FREE_ADDR = 2'd2,
    CMD_LOOKUP    = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK      = 2'd0,
    ST_NO_GAP  = 2'd1,
    ST_NO_SLOT = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_DISPATCH,
    S_OWN_RD,
    S_OWN_CHK,
    S_SCAN,
    S_SLOT,
    S_MARK,
    S_RELEASE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [SizeW-1:0] request_size;
    logic [SlotW-1:0] slot_in;
    logic [AddrW-1:0] cell_addr;
  } req_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [AddrW-1:0] region_start;
    logic [SizeW-1:0] region_length;
    logic [SlotW-1:0] slot_out;
  } rsp_t;

endpackage

// ----- src/first_fit_cell_region_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// first_fit_cell_region_allocator_unit: first-fit allocator over a cell tape
// Allocates, frees and looks up contiguous cell regions with a small sequencer.
// ----------------------------------------------------------------------------
// Usage: one command beat at a time. After reset the unit sweeps the owner
// memory to zero while in_stall_o is high. Each command then runs on one
// shared address counter and one compare over the owner memory (one read
// or one write per cycle):
//   allocate  : scan the tape up to the end of the first fit, search the
//               slots for the lowest free one, then mark request_size cells,
//   free      : read the owner cell (free by address only), then clear the region,
//   lookup    : read the owner cell and return the region of its slot.
// The result beat sits in an output register; the next command is taken once
// that beat has left.
module first_fit_cell_region_allocator_unit #(
  parameter int unsigned TAPE_CELLS  = ffcra_pkg::TapeCellsDef,
  parameter int unsigned MAX_REGIONS = ffcra_pkg::MaxRegionsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ffcra_pkg::req_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ffcra_pkg::rsp_t   out_data_o
);
  import ffcra_pkg::*;

  localparam int unsigned CW  = $clog2(TAPE_CELLS);       // cell index
  localparam int unsigned CCW = $clog2(TAPE_CELLS + 1);   // cell count
  localparam int unsigned RW  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned RCW = $clog2(MAX_REGIONS + 1);
  localparam int unsigned OW  = $clog2(MAX_REGIONS + 1);  // owner code, 0 = free
  localparam int unsigned LW  = (CCW > SizeW) ? CCW : SizeW;

  // Owner memory: one write and one registered read per cycle.
  logic [OW-1:0] owner_mem [TAPE_CELLS];
  logic [OW-1:0] rd_data_q;
  logic          mem_we;
  logic [CW-1:0] mem_addr;
  logic [OW-1:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      owner_mem[mem_addr] <= mem_wdata;
    end
    rd_data_q <= owner_mem[mem_addr];
  end

  // Slot table: small register arrays, written at the one slot register.
  logic [MAX_REGIONS-1:0] used_q, used_d;
  logic [AddrW-1:0]       sstart_q [MAX_REGIONS];
  logic [SizeW-1:0]       slen_q   [MAX_REGIONS];
  logic                   slot_we;

  state_e          state_q, state_d;
  req_t            req_q, req_d;
  rsp_t            rsp_q, rsp_d;
  logic            ovalid_q, ovalid_d;
  logic [CCW-1:0]  idx_q, idx_d;       // shared cell counter
  logic [LW-1:0]   run_q, run_d;       // free run length / remaining count
  logic [CW-1:0]   base_q, base_d;     // region start being worked on
  logic [RW-1:0]   slot_q, slot_d;
  logic [RCW-1:0]  sidx_q, sidx_d;
  logic            rdv_q, rdv_d;       // rd_data_q holds the cell of idx_q-1

  logic [LW-1:0]   size_ext;
  logic [LW-1:0]   run_inc;

  assign size_ext = LW'(req_q.request_size);
  assign run_inc  = run_q + LW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      ovalid_q <= 1'b0;
      used_q   <= '0;
      idx_q    <= '0;
      rdv_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      used_q   <= used_d;
      idx_q    <= idx_d;
      rdv_q    <= rdv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    rsp_q  <= rsp_d;
    run_q  <= run_d;
    base_q <= base_d;
    slot_q <= slot_d;
    sidx_q <= sidx_d;
    if (slot_we) begin
      sstart_q[slot_q] <= AddrW'(base_q);
      slen_q[slot_q]   <= req_q.request_size;
    end
  end

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    rsp_d     = rsp_q;
    ovalid_d  = ovalid_q;
    idx_d     = idx_q;
    run_d     = run_q;
    base_d    = base_q;
    slot_d    = slot_q;
    sidx_d    = sidx_q;
    rdv_d     = 1'b0;
    used_d    = used_q;
    slot_we   = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = idx_q[CW-1:0];
    mem_wdata = '0;
    in_stall_o = 1'b1;

    if (ovalid_q && !out_stall_i) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        // Sweep the owner memory to free after reset.
        mem_we = 1'b1;
        if (idx_q == CCW'(TAPE_CELLS - 1)) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + CCW'(1);
        end
      end
      S_IDLE: begin
        in_stall_o = ovalid_q;
        if (in_valid_i && !ovalid_q) begin
          req_d   = in_data_i;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        rsp_d = '0;
        rsp_d.status = ST_INVALID;
        idx_d = '0;
        run_d = '0;
        case (cmd_e'(req_q.cmd))
          CMD_ALLOC: begin
            if (req_q.request_size == '0) begin
              state_d = S_DONE;
            end else begin
              rsp_d.status = ST_NO_GAP;
              state_d = S_SCAN;
            end
          end
          CMD_FREE_SLOT: begin
            if (32'(req_q.slot_in) < MAX_REGIONS && used_q[RW'(req_q.slot_in)]) begin
              slot_d  = RW'(req_q.slot_in);
              base_d  = CW'(sstart_q[RW'(req_q.slot_in)]);
              run_d   = LW'(slen_q[RW'(req_q.slot_in)]);
              idx_d   = CCW'(sstart_q[RW'(req_q.slot_in)]);
              state_d = S_RELEASE;
            end else begin
              state_d = S_DONE;
            end
          end
          default: begin
            if (32'(req_q.cell_addr) < TAPE_CELLS) begin
              idx_d   = CCW'(req_q.cell_addr);
              state_d = S_OWN_RD;
            end else begin
              state_d = S_DONE;
            end
          end
        endcase
      end
      S_OWN_RD: begin
        state_d = S_OWN_CHK;   // read issued at idx_q
      end
      S_OWN_CHK: begin
        if (rd_data_q == '0 || 32'(rd_data_q) > MAX_REGIONS ||
            !used_q[RW'(rd_data_q - OW'(1))]) begin
          state_d = S_DONE;
        end else begin
          slot_d = RW'(rd_data_q - OW'(1));
          base_d = CW'(sstart_q[RW'(rd_data_q - OW'(1))]);
          run_d  = LW'(slen_q[RW'(rd_data_q - OW'(1))]);
          if (cmd_e'(req_q.cmd) == CMD_LOOKUP) begin
            rsp_d.status        = ST_OK;
            rsp_d.region_start  = sstart_q[RW'(rd_data_q - OW'(1))];
            rsp_d.region_length = slen_q[RW'(rd_data_q - OW'(1))];
            rsp_d.slot_out      = SlotW'(rd_data_q - OW'(1));
            state_d = S_DONE;
          end else begin
            idx_d   = CCW'(sstart_q[RW'(rd_data_q - OW'(1))]);
            state_d = S_RELEASE;
          end
        end
      end
      S_SCAN: begin
        // Issue a read at idx_q; judge the cell read in the previous cycle.
        if (rdv_q) begin
          if (rd_data_q == '0) begin
            run_d = run_inc;
            if (run_inc >= size_ext) begin
              base_d  = CW'(idx_q - CCW'(1) - CCW'(size_ext - LW'(1)));
              sidx_d  = '0;
              state_d = S_SLOT;
            end
          end else begin
            run_d = '0;
          end
        end
        if (state_d == S_SCAN) begin
          if (idx_q == CCW'(TAPE_CELLS)) begin
            state_d = S_DONE;   // status already no gap
          end else begin
            idx_d = idx_q + CCW'(1);
            rdv_d = 1'b1;
          end
        end
      end
      S_SLOT: begin
        // Lowest free slot, one per cycle.
        if (sidx_q == RCW'(MAX_REGIONS)) begin
          rsp_d.status = ST_NO_SLOT;
          state_d = S_DONE;
        end else if (!used_q[RW'(sidx_q)]) begin
          slot_d  = RW'(sidx_q);
          idx_d   = CCW'(base_q);
          run_d   = size_ext;
          state_d = S_MARK;
        end else begin
          sidx_d = sidx_q + RCW'(1);
        end
      end
      S_MARK: begin
        mem_we    = 1'b1;
        mem_wdata = OW'(slot_q) + OW'(1);
        idx_d     = idx_q + CCW'(1);
        run_d     = run_q - LW'(1);
        if (run_q == LW'(1)) begin
          used_d[slot_q] = 1'b1;
          slot_we = 1'b1;
          rsp_d.status        = ST_OK;
          rsp_d.region_start  = AddrW'(base_q);
          rsp_d.region_length = req_q.request_size;
          rsp_d.slot_out      = SlotW'(slot_q);
          state_d = S_DONE;
        end
      end
      S_RELEASE: begin
        if (run_q == '0) begin
          used_d[slot_q] = 1'b0;
          rsp_d.status        = ST_OK;
          rsp_d.region_start  = sstart_q[slot_q];
          rsp_d.region_length = slen_q[slot_q];
          rsp_d.slot_out      = SlotW'(slot_q);
          state_d = S_DONE;
        end else begin
          mem_we = (32'(idx_q) < TAPE_CELLS);
          idx_d  = idx_q + CCW'(1);
          run_d  = run_q - LW'(1);
        end
      end
      S_DONE: begin
        ovalid_d = 1'b1;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = rsp_q;

  // A result beat only appears from the done step.
  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q) == S_DONE) else $error("beat without done");
  // Stall input while a command is in flight.
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> in_stall_o) else $error("accepted while busy");
  // A marking pass always ends on a slot that was free.
  a_mark_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MARK |-> !used_q[slot_q]) else $error("marking a used slot");
  // An ok allocate result adds exactly one used slot.
  a_alloc_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MARK && state_d == S_DONE) |=>
      $countones(used_q) == $countones($past(used_q)) + 1) else $error("slot count");

endmodule

// ----- tb/ffcra_checker.sv -----
// ----------------------------------------------------------------------------
// ffcra_checker: response predictor and scoreboard for the region allocator
// Watches both channels, models the tape and slots, compares every beat.
// ----------------------------------------------------------------------------
module ffcra_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  ffcra_pkg::req_t   in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  ffcra_pkg::rsp_t   out_data_i,
  output int                fail_count_o,
  output int                pending_o
);
  import ffcra_pkg::*;

  localparam int unsigned Cells = TapeCellsDef;
  localparam int unsigned Slots = MaxRegionsDef;

  logic [4:0]       owner_q [Cells];
  logic             used_q  [Slots];
  logic [AddrW-1:0] start_q [Slots];
  logic [SizeW-1:0] len_q   [Slots];
  rsp_t             rsp_queue[$];

  function automatic rsp_t make_rsp(status_e st, int unsigned s, int unsigned l,
                                    int unsigned sl);
    rsp_t r;
    r.status        = st;
    r.region_start  = s[AddrW-1:0];
    r.region_length = l[SizeW-1:0];
    r.slot_out      = sl[SlotW-1:0];
    return r;
  endfunction

  function automatic rsp_t release_region(int unsigned sl);
    for (int unsigned i = 0; i < len_q[sl]; i++)
      if (start_q[sl] + i < Cells) owner_q[start_q[sl] + i] = '0;
    used_q[sl] = 1'b0;
    return make_rsp(ST_OK, start_q[sl], len_q[sl], sl);
  endfunction

  // Return slot+1 owning the cell, or zero when free.
  function automatic int unsigned owning_slot(logic [AddrW-1:0] a);
    int unsigned o;
    o = owner_q[a];
    if (o == 0 || o > Slots || !used_q[o-1]) return 0;
    return o;
  endfunction

  function automatic rsp_t predict_rsp(req_t q);
    int unsigned run, pos, sl, o;
    case (cmd_e'(q.cmd))
      CMD_ALLOC: begin
        if (q.request_size == 0) return make_rsp(ST_INVALID, 0, 0, 0);
        run = 0;
        pos = Cells;
        for (int unsigned i = 0; i < Cells; i++) begin
          if (owner_q[i] == 0) begin
            run++;
            if (run >= q.request_size) begin
              pos = i + 1 - q.request_size;
              break;
            end
          end else begin
            run = 0;
          end
        end
        if (pos == Cells) return make_rsp(ST_NO_GAP, 0, 0, 0);
        sl = Slots;
        for (int unsigned s = 0; s < Slots; s++)
          if (!used_q[s]) begin
            sl = s;
            break;
          end
        if (sl == Slots) return make_rsp(ST_NO_SLOT, 0, 0, 0);
        used_q[sl]  = 1'b1;
        start_q[sl] = pos[AddrW-1:0];
        len_q[sl]   = q.request_size;
        for (int unsigned i = 0; i < q.request_size; i++) owner_q[pos + i] = 5'(sl + 1);
        return make_rsp(ST_OK, pos, q.request_size, sl);
      end
      CMD_FREE_SLOT: begin
        if (!used_q[q.slot_in]) return make_rsp(ST_INVALID, 0, 0, 0);
        return release_region(q.slot_in);
      end
      CMD_FREE_ADDR: begin
        o = owning_slot(q.cell_addr);
        if (o == 0) return make_rsp(ST_INVALID, 0, 0, 0);
        return release_region(o - 1);
      end
      default: begin
        o = owning_slot(q.cell_addr);
        if (o == 0) return make_rsp(ST_INVALID, 0, 0, 0);
        return make_rsp(ST_OK, start_q[o-1], len_q[o-1], o - 1);
      end
    endcase
  endfunction

  assign pending_o = rsp_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Cells; i++) owner_q[i] = '0;
      for (int i = 0; i < Slots; i++) begin
        used_q[i]  = 1'b0;
        start_q[i] = '0;
        len_q[i]   = '0;
      end
      rsp_queue.delete();
      fail_count_o <= 0;
    end else begin
      // Check the result beat before predicting; only one command is in flight.
      if (out_valid_i && !out_stall_i) begin
        if (rsp_queue.size() == 0) begin
          if (fail_count_o < 10) $display("ERROR: unexpected result beat %p", out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = rsp_queue.pop_front();
          if (want !== out_data_i) begin
            if (fail_count_o < 10)
              $display({"ERROR: result mismatch exp st=%0d start=%0d len=%0d sl=%0d",
                        " act st=%0d start=%0d len=%0d sl=%0d"},
                       want.status, want.region_start, want.region_length, want.slot_out,
                       out_data_i.status, out_data_i.region_start,
                       out_data_i.region_length, out_data_i.slot_out);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) rsp_queue.push_back(predict_rsp(in_data_i));
    end
  end

endmodule

// ----- tb/tb_first_fit_cell_region_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// tb_first_fit_cell_region_allocator_unit: stimulus and verdict for the allocator
// Directed corner beats, then random mixes of allocate, free and lookup under
// several idle/stall phases; the checker predicts and scores every result.
// ----------------------------------------------------------------------------
module tb_first_fit_cell_region_allocator_unit;
  import ffcra_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;
  int   fail_count;
  int   pending;

  // Idle percentages, changed per phase; the hold-off flag forces a long stall.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_off = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  first_fit_cell_region_allocator_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  ffcra_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Drive receiver stall: random by phase, forced high during the hold-off.
  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Send one beat: optional idle gap, then hold valid until accepted.
  // Valid is left high on return; the next beat or drain() takes it over.
  task automatic send_beat(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic req_t mk(cmd_e c, int unsigned sz, int unsigned sl, int unsigned a);
    req_t r;
    r.cmd          = c;
    r.request_size = sz[SizeW-1:0];
    r.slot_in      = sl[SlotW-1:0];
    r.cell_addr    = a[AddrW-1:0];
    return r;
  endfunction

  // Random beat: allocations, mostly of small sizes, frees of random slots
  // and addresses, and lookups, with large sizes and junk mixed in.
  function automatic req_t rand_beat();
    int unsigned p;
    req_t r;
    r = req_t'(($bits(req_t))'($urandom));
    p = $urandom_range(99);
    if (p < 40) begin
      r.cmd = CMD_ALLOC;
      case ($urandom_range(9))
        0:       r.request_size = SizeW'($urandom_range(511));
        1:       r.request_size = SizeW'($urandom_range(256, 128));
        default: r.request_size = SizeW'($urandom_range(24, 1));
      endcase
    end else if (p < 60) begin
      r.cmd = CMD_FREE_SLOT;
    end else if (p < 75) begin
      r.cmd = CMD_FREE_ADDR;
    end else begin
      r.cmd = CMD_LOOKUP;
    end
    return r;
  endfunction

  // Drop valid, then wait for every predicted result to come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    #2000000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero size, oversize, full tape, exhaust slots, frees, lookups.
    send_beat(mk(CMD_ALLOC, 0, 0, 0));
    send_beat(mk(CMD_ALLOC, 511, 0, 0));
    send_beat(mk(CMD_ALLOC, 257, 0, 0));
    send_beat(mk(CMD_LOOKUP, 0, 0, 0));
    send_beat(mk(CMD_FREE_SLOT, 0, 15, 0));
    send_beat(mk(CMD_FREE_ADDR, 0, 0, 255));
    send_beat(mk(CMD_ALLOC, 256, 0, 0));
    send_beat(mk(CMD_LOOKUP, 0, 0, 255));
    send_beat(mk(CMD_ALLOC, 1, 0, 0));
    send_beat(mk(CMD_FREE_ADDR, 0, 0, 128));
    for (int i = 0; i < 16; i++) send_beat(mk(CMD_ALLOC, 1, 0, 0));
    send_beat(mk(CMD_ALLOC, 1, 0, 0));
    send_beat(mk(CMD_ALLOC, 250, 0, 0));
    send_beat(mk(CMD_FREE_SLOT, 0, 15, 0));
    send_beat(mk(CMD_LOOKUP, 0, 0, 3));
    send_beat(mk(CMD_FREE_ADDR, 0, 0, 3));
    drain();

    // Random phases: none, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 47 : (ph == 3) ? 33 : 0;
      recv_stall_pct = (ph == 2) ? 47 : (ph == 3) ? 33 : 0;
      for (int n = 0; n < 400; n++) send_beat(rand_beat());
    end
    drain();

    // Pressure: stall the receiver long while beats keep arriving.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int n = 0; n < 30; n++) send_beat(rand_beat());
    join
    drain();
    repeat (600) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
